// ===== rtl/core/tick_clock_with_task_alarms_core_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef TICK_CLOCK_WITH_TASK_ALARMS_CORE_MACROS_SVH
`define TICK_CLOCK_WITH_TASK_ALARMS_CORE_MACROS_SVH

// same-cycle implication
`define TCTA_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication
`define TCTA_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// condition that must never hold
`define TCTA_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/core/tcta_pkg.sv =====
package tcta_pkg;

  localparam int TCTA_TASK_SLOTS = 16;
  localparam logic [7:0] TPS_RESET = 8'd250;
  localparam int DIV_W = 17;
  localparam logic signed [15:0] SLICE_MIN = 16'sh8000;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_ARM   = 2'd1;
  localparam logic [1:0] REQ_SLICE = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               task_present;
    logic [3:0]         task_index;
    logic [31:0]        alarm_seconds;
    logic [7:0]         alarm_subtick;
    logic [15:0]        repeat_ticks;
    logic signed [15:0] slice_value;
  } req_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  signal_task;
    logic [31:0] wall_seconds;
    logic [7:0]  wall_subtick;
    logic [31:0] uptime_seconds;
    logic [7:0]  cpu_ticks_last;
    logic        resched;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] sec;
    logic [7:0]  tick;
    logic [15:0] rep;
  } slot_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [7:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [7:0]       remainder;
  } div_rsp_t;

  function automatic logic time_due(input logic [31:0] sec, input logic [7:0] tick,
                                    input logic [31:0] now_sec, input logic [7:0] now_tick);
    return ((sec == now_sec) && (tick <= now_tick)) || (sec < now_sec);
  endfunction

  function automatic logic offer_ok(input logic [31:0] sec, input logic [7:0] tick,
                                    input logic [31:0] cur_sec, input logic [7:0] cur_tick);
    return (cur_sec == 32'd0) || (sec < cur_sec) || ((sec == cur_sec) && (tick < cur_tick));
  endfunction

endpackage

// ===== rtl/core/tcta_ifs.sv =====
interface tcta_req_if import tcta_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcta_rsp_if import tcta_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcta_cfg_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tcta_div.sv =====
module tcta_div import tcta_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t dreq,
  output div_rsp_t drsp,
  output logic     busy
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo;
  logic [8:0]       rem;
  logic [7:0]       dvs;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [8:0]       rem_sh;
  logic [8:0]       rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem[7:0], quo[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (dreq.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (dreq.start) begin
      quo <= dreq.dividend;
      rem <= '0;
      dvs <= dreq.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= ge ? rem_sub : rem_sh;
    end
  end

  assign drsp.done      = done;
  assign drsp.quotient  = quo;
  assign drsp.remainder = rem[7:0];

endmodule

// ===== rtl/core/tick_clock_with_task_alarms_core.sv =====
// Tick clock with per-task alarms.
// Channels: req (sink) carries ticks, alarm arms and slice loads; rsp (source)
// carries results; cfg (sink) writes ticks_per_second, taken at once.
// Every request yields zero or more alarm results (fired=1) and then one
// status result (last=1); all of them show the time state after the request.
// Flow: an arm, a slice load or an unknown code goes straight to the status
// result, a tick first checks for a due alarm. A tick that reaches the earliest
// alarm walks the slot table held in a one-port synchronous memory: each slot is
// read and then checked, each fired slot sends a signal result, and each repeating
// fired slot is re-armed through a bit-serial 17-bit divider.
// Results go through a two-entry output queue; a request is taken even while
// results still wait, and when the receiver stalls with the queue full the
// walk holds until space opens.
// Reset: wall time 1 s, uptime 0, counters and flags zero, rate 250, all
// slots disarmed (per-slot valid bits, no clearing pass).
module tick_clock_with_task_alarms_core import tcta_pkg::*; #(
  parameter int TASK_SLOTS = TCTA_TASK_SLOTS
) (
  input logic         clk,
  input logic         rst,
  tcta_req_if.sink    req,
  tcta_rsp_if.source  rsp,
  tcta_cfg_if.sink    cfg
);

  `include "tick_clock_with_task_alarms_core_macros.svh"

  localparam int IDXW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_SIG  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_STAT = 3'd6;

  logic [2:0]         state;
  logic [7:0]         tps;
  logic [31:0]        wall_sec;
  logic [7:0]         wall_tick;
  logic [31:0]        up_sec;
  logic [7:0]         up_tick;
  logic [7:0]         busy_count;
  logic [7:0]         busy_last;
  logic signed [15:0] slice_count;
  logic               resched_flag;
  logic [31:0]        na_sec;
  logic [7:0]         na_tick;
  logic [IDXW-1:0]    slot_idx;
  logic [TASK_SLOTS-1:0] slot_vld;

  slot_t mem [TASK_SLOTS];
  slot_t rd_data;
  logic  rd_vld;
  logic  rd_en;
  logic  mem_we;
  logic [IDXW-1:0] mem_waddr;
  slot_t mem_wdata;

  rsp_t       fifo_q [2];
  logic [1:0] fifo_cnt;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       fifo_room;
  logic       push;
  logic       pop;
  rsp_t       push_data;

  div_req_t dreq;
  div_rsp_t drsp;
  logic     div_busy;

  logic               accept;
  logic [7:0]         hz;
  slot_t              ent;
  logic [8:0]         up_tick_inc;
  logic [8:0]         wall_tick_inc;
  logic               up_wrap;
  logic               wall_wrap;
  logic [7:0]         busy_inc;
  logic signed [15:0] slice_dec;
  logic               idx_ok;
  logic [IDXW-1:0]    arm_addr;
  logic               last_slot;
  logic [31:0]        rearm_sec;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;

  always_comb begin
    hz            = (tps == 8'd0) ? 8'd1 : tps;
    ent           = rd_vld ? rd_data : '0;
    up_tick_inc   = {1'b0, up_tick} + 9'd1;
    wall_tick_inc = {1'b0, wall_tick} + 9'd1;
    up_wrap       = up_tick_inc >= {1'b0, hz};
    wall_wrap     = wall_tick_inc >= {1'b0, hz};
    busy_inc      = (req.data.task_present && busy_count != 8'hFF) ?
                    busy_count + 8'd1 : busy_count;
    slice_dec     = (slice_count != SLICE_MIN) ? slice_count - 16'sd1 : slice_count;
    idx_ok        = int'(req.data.task_index) < TASK_SLOTS;
    arm_addr      = IDXW'(req.data.task_index);
    last_slot     = slot_idx == IDXW'(TASK_SLOTS - 1);
    rearm_sec     = wall_sec + 32'(drsp.quotient);
  end

  // divider for the re-arm time
  always_comb begin
    dreq.start    = (state == S_SIG) && fifo_room && (ent.rep != 16'd0);
    dreq.dividend = DIV_W'(wall_tick) + DIV_W'(ent.rep);
    dreq.divisor  = hz;
  end

  tcta_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp),
    .busy (div_busy)
  );

  // slot memory port control
  always_comb begin
    rd_en     = (state == S_RD);
    mem_we    = 1'b0;
    mem_waddr = slot_idx;
    mem_wdata = ent;
    unique case (state)
      S_IDLE: begin
        if (accept && req.data.req_type == REQ_ARM && idx_ok) begin
          mem_we         = 1'b1;
          mem_waddr      = arm_addr;
          mem_wdata.sec  = req.data.alarm_seconds;
          mem_wdata.tick = req.data.alarm_subtick;
          mem_wdata.rep  = req.data.repeat_ticks;
        end
      end
      S_SIG: begin
        if (fifo_room && ent.rep == 16'd0) begin
          mem_we        = 1'b1;
          mem_wdata.sec = 32'd0;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          mem_we         = 1'b1;
          mem_wdata.sec  = rearm_sec;
          mem_wdata.tick = drsp.remainder;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[slot_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (rd_en) begin
      rd_vld <= slot_vld[slot_idx];
    end
  end

  // result queue
  always_comb begin
    fifo_room              = fifo_cnt != 2'd2;
    pop                    = rsp.valid && rsp.ready;
    push                   = ((state == S_SIG) || (state == S_STAT)) && fifo_room;
    push_data.fired        = (state == S_SIG);
    push_data.signal_task  = (state == S_SIG) ? 4'(slot_idx) : 4'd0;
    push_data.wall_seconds = wall_sec;
    push_data.wall_subtick = wall_tick;
    push_data.uptime_seconds = up_sec;
    push_data.cpu_ticks_last = busy_last;
    push_data.resched      = resched_flag;
    push_data.last         = (state == S_STAT);
  end

  assign rsp.valid = fifo_cnt != 2'd0;
  assign rsp.data  = fifo_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_cnt <= 2'd0;
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fifo_cnt <= fifo_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wr_ptr] <= push_data;
    end
  end

  // sequencer and time state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tps          <= TPS_RESET;
      wall_sec     <= 32'd1;
      wall_tick    <= 8'd0;
      up_sec       <= 32'd0;
      up_tick      <= 8'd0;
      busy_count   <= 8'd0;
      busy_last    <= 8'd0;
      slice_count  <= 16'sd0;
      resched_flag <= 1'b0;
      na_sec       <= 32'd0;
      na_tick      <= 8'd0;
      slot_idx     <= '0;
      slot_vld     <= '0;
    end else begin
      if (cfg.valid) begin
        tps <= cfg.data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.data.req_type)
              REQ_TICK: begin
                if (up_wrap) begin
                  busy_last  <= busy_inc;
                  busy_count <= 8'd0;
                  up_tick    <= 8'd0;
                  up_sec     <= up_sec + 32'd1;
                end else begin
                  busy_count <= busy_inc;
                  up_tick    <= up_tick_inc[7:0];
                end
                if (wall_wrap) begin
                  wall_tick <= 8'd0;
                  wall_sec  <= wall_sec + 32'd1;
                end else begin
                  wall_tick <= wall_tick_inc[7:0];
                end
                if (req.data.task_present) begin
                  slice_count <= slice_dec;
                  if (slice_dec[15]) begin
                    resched_flag <= 1'b1;
                  end
                end
                state <= S_CHK;
              end
              REQ_ARM: begin
                if (idx_ok) begin
                  slot_vld[arm_addr] <= 1'b1;
                  if (req.data.alarm_seconds != 32'd0 &&
                      offer_ok(req.data.alarm_seconds, req.data.alarm_subtick,
                               na_sec, na_tick)) begin
                    na_sec  <= req.data.alarm_seconds;
                    na_tick <= req.data.alarm_subtick;
                  end
                end
                state <= S_STAT;
              end
              REQ_SLICE: begin
                slice_count <= req.data.slice_value;
                state       <= S_STAT;
              end
              default: begin
                state <= S_STAT;
              end
            endcase
          end
        end
        S_CHK: begin
          if (na_sec != 32'd0 && time_due(na_sec, na_tick, wall_sec, wall_tick)) begin
            na_sec   <= 32'd0;
            slot_idx <= '0;
            state    <= S_RD;
          end else begin
            state <= S_STAT;
          end
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (ent.sec != 32'd0 && time_due(ent.sec, ent.tick, wall_sec, wall_tick)) begin
            state <= S_SIG;
          end else begin
            if (ent.sec != 32'd0 && offer_ok(ent.sec, ent.tick, na_sec, na_tick)) begin
              na_sec  <= ent.sec;
              na_tick <= ent.tick;
            end
            if (last_slot) begin
              state <= S_STAT;
            end else begin
              slot_idx <= slot_idx + 1'b1;
              state    <= S_RD;
            end
          end
        end
        S_SIG: begin
          if (fifo_room) begin
            if (ent.rep != 16'd0) begin
              state <= S_DIV;
            end else if (last_slot) begin
              state <= S_STAT;
            end else begin
              slot_idx <= slot_idx + 1'b1;
              state    <= S_RD;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            if (rearm_sec != 32'd0 &&
                offer_ok(rearm_sec, drsp.remainder, na_sec, na_tick)) begin
              na_sec  <= rearm_sec;
              na_tick <= drsp.remainder;
            end
            if (last_slot) begin
              state <= S_STAT;
            end else begin
              slot_idx <= slot_idx + 1'b1;
              state    <= S_RD;
            end
          end
        end
        S_STAT: begin
          if (fifo_room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TCTA_NEVER(a_fifo_bound, fifo_cnt == 2'd3)
  `TCTA_IMPLY(a_div_idle_on_start, dreq.start, !div_busy)
  `TCTA_NEVER(a_mem_port_clash, mem_we && rd_en)
  `TCTA_NEXT(a_wall_tick_wraps, accept && req.data.req_type == REQ_TICK, wall_tick < hz)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tcta_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 30;

  class alarm_clock_tracker;
    logic [7:0]  tick_rate;
    logic [31:0] wall_sec;
    logic [31:0] up_sec;
    logic [31:0] next_sec;
    int          wall_tick;
    int          up_tick;
    int          next_tick;
    int          busy_count;
    int          busy_last;
    int          slice_left;
    bit          resched;
    logic [31:0] slot_sec [TCTA_TASK_SLOTS];
    int          slot_tick [TCTA_TASK_SLOTS];
    int          slot_rep [TCTA_TASK_SLOTS];
    rsp_t        expected_rsps [$];
    int          errors;
    int          checked;
    int          fired_count;
    int          most_per_request;

    function new();
      tick_rate = TPS_RESET;
      wall_sec = 32'd1;
      up_sec = 32'd0;
      next_sec = 32'd0;
      wall_tick = 0;
      up_tick = 0;
      next_tick = 0;
      busy_count = 0;
      busy_last = 0;
      slice_left = 0;
      resched = 1'b0;
      for (int i = 0; i < TCTA_TASK_SLOTS; i++) begin
        slot_sec[i] = 32'd0;
        slot_tick[i] = 0;
        slot_rep[i] = 0;
      end
      errors = 0;
      checked = 0;
      fired_count = 0;
      most_per_request = 0;
    endfunction

    function void set_rate(logic [7:0] value);
      tick_rate = value;
    endfunction

    function int hz();
      return (tick_rate == 8'd0) ? 1 : int'(tick_rate);
    endfunction

    function bit reached(logic [31:0] sec, int tick);
      return ((sec == wall_sec) && (tick <= wall_tick)) || (sec < wall_sec);
    endfunction

    function void lower_earliest(logic [31:0] sec, int tick);
      if (next_sec == 32'd0 || sec < next_sec || (sec == next_sec && tick < next_tick)) begin
        next_sec = sec;
        next_tick = tick;
      end
    endfunction

    function void note_request(req_t r);
      int          fired_slots [$];
      int          rate;
      int          t;
      logic [31:0] s;
      rsp_t        e;
      rate = hz();
      case (r.req_type)
        REQ_TICK: begin
          if (r.task_present && busy_count < 255) busy_count++;
          up_tick++;
          if (up_tick >= rate) begin
            busy_last = busy_count;
            busy_count = 0;
            up_tick = 0;
            up_sec = up_sec + 32'd1;
          end
          wall_tick++;
          if (wall_tick >= rate) begin
            wall_tick = 0;
            wall_sec = wall_sec + 32'd1;
          end
          if (r.task_present) begin
            if (slice_left > -32768) slice_left--;
            if (slice_left < 0) resched = 1'b1;
          end
          if (next_sec != 32'd0 && reached(next_sec, next_tick)) begin
            next_sec = 32'd0;
            for (int i = 0; i < TCTA_TASK_SLOTS; i++) begin
              if (slot_sec[i] == 32'd0) continue;
              if (reached(slot_sec[i], slot_tick[i])) begin
                fired_slots.push_back(i);
                slot_sec[i] = 32'd0;
                if (slot_rep[i] != 0) begin
                  t = wall_tick + slot_rep[i];
                  s = wall_sec;
                  if (t >= rate) begin
                    s = s + 32'(t / rate);
                    t = t % rate;
                  end
                  slot_sec[i] = s;
                  slot_tick[i] = t & 255;
                  if (s != 32'd0) lower_earliest(s, slot_tick[i]);
                end
              end else begin
                lower_earliest(slot_sec[i], slot_tick[i]);
              end
            end
          end
        end
        REQ_ARM: begin
          slot_sec[r.task_index] = r.alarm_seconds;
          slot_tick[r.task_index] = int'(r.alarm_subtick);
          slot_rep[r.task_index] = int'(r.repeat_ticks);
          if (r.alarm_seconds != 32'd0) lower_earliest(r.alarm_seconds, int'(r.alarm_subtick));
        end
        REQ_SLICE: slice_left = $signed(r.slice_value);
        default: ;
      endcase

      e.wall_seconds = wall_sec;
      e.wall_subtick = wall_tick[7:0];
      e.uptime_seconds = up_sec;
      e.cpu_ticks_last = busy_last[7:0];
      e.resched = resched;
      foreach (fired_slots[k]) begin
        e.fired = 1'b1;
        e.signal_task = fired_slots[k][3:0];
        e.last = 1'b0;
        expected_rsps.push_back(e);
      end
      e.fired = 1'b0;
      e.signal_task = 4'd0;
      e.last = 1'b1;
      expected_rsps.push_back(e);
      fired_count += fired_slots.size();
      if (fired_slots.size() + 1 > most_per_request) most_per_request = fired_slots.size() + 1;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      checked++;
      if (expected_rsps.size() == 0) begin
        $error("result with nothing expected: fired %0b task %0d last %0b",
               got.fired, got.signal_task, got.last);
        errors++;
        return;
      end
      e = expected_rsps.pop_front();
      compare("fired", 32'(e.fired), 32'(got.fired));
      compare("signal_task", 32'(e.signal_task), 32'(got.signal_task));
      compare("wall_seconds", e.wall_seconds, got.wall_seconds);
      compare("wall_subtick", 32'(e.wall_subtick), 32'(got.wall_subtick));
      compare("uptime_seconds", e.uptime_seconds, got.uptime_seconds);
      compare("cpu_ticks_last", 32'(e.cpu_ticks_last), 32'(got.cpu_ticks_last));
      compare("resched", 32'(e.resched), 32'(got.resched));
      compare("last", 32'(e.last), 32'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst;

  tcta_req_if req_ch ();
  tcta_rsp_if rsp_ch ();
  tcta_cfg_if cfg_ch ();

  tick_clock_with_task_alarms_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  alarm_clock_tracker sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int requests_sent = 0;
  logic [7:0] last_random_rate;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
  end

  function automatic req_t random_fill();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic req_t arm_request(logic [3:0] slot, logic [31:0] sec, logic [7:0] tick);
    req_t r;
    int   p;
    r = random_fill();
    r.req_type = REQ_ARM;
    r.task_index = slot;
    r.alarm_seconds = sec;
    r.alarm_subtick = tick;
    p = $urandom_range(0, 99);
    if (p < 25) r.repeat_ticks = 16'd0;
    else if (p < 70) r.repeat_ticks = 16'($urandom_range(1, 15));
    else if (p < 88) r.repeat_ticks = 16'($urandom_range(16, 700));
    else r.repeat_ticks = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic void pick_alarm_time(output logic [31:0] sec, output logic [7:0] tick);
    int rate;
    int p;
    int target;
    rate = sb.hz();
    p = $urandom_range(0, 99);
    if (p < 8) begin
      sec = $urandom;
      tick = 8'($urandom_range(0, 255));
    end else if (p < 13) begin
      sec = 32'd0;
      tick = 8'($urandom_range(0, 255));
    end else if (p < 28) begin
      // current or previous second with any subtick, so often already passed or beyond the rate
      sec = sb.wall_sec - 32'($urandom_range(0, 1));
      tick = 8'($urandom_range(0, 255));
    end else begin
      target = sb.wall_tick + $urandom_range(0, 10);
      sec = sb.wall_sec + 32'(target / rate);
      tick = 8'(target % rate);
    end
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int          p;
    logic [31:0] sec;
    logic [7:0]  tick;
    p = $urandom_range(0, 99);
    if (p < 58) begin
      r = random_fill();
      r.req_type = REQ_TICK;
      r.task_present = ($urandom_range(0, 9) < 7);
    end else if (p < 88) begin
      pick_alarm_time(sec, tick);
      r = arm_request(4'($urandom_range(0, 15)), sec, tick);
    end else if (p < 96) begin
      r = random_fill();
      r.req_type = REQ_SLICE;
      if ($urandom_range(0, 1)) r.slice_value = 16'($urandom_range(0, 40)) - 16'sd8;
    end else begin
      r = random_fill();
      r.req_type = REQ_UNKNOWN;
    end
    return r;
  endfunction

  task automatic send_request(input req_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= item;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(item);
    requests_sent++;
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.expected_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_rate(value);
  endtask

  task automatic run_directed();
    req_t r;
    r = random_fill();
    r.req_type = REQ_UNKNOWN;
    send_request(r);
    r = random_fill();
    r.req_type = REQ_SLICE;
    r.slice_value = 16'sh7fff;
    send_request(r);
    r = random_fill();
    r.req_type = REQ_TICK;
    r.task_present = 1'b1;
    send_request(r);
    r = random_fill();
    r.req_type = REQ_SLICE;
    r.slice_value = SLICE_MIN;
    send_request(r);
    // slice sits at its floor, reschedule goes up
    r = random_fill();
    r.req_type = REQ_TICK;
    r.task_present = 1'b1;
    send_request(r);
    for (int i = 0; i < TCTA_TASK_SLOTS; i++) begin
      r = arm_request(i[3:0], 32'd1, (i == 12) ? 8'hff : 8'(i % 3));
      if (i == 0) r.repeat_ticks = 16'hffff;
      else if (i == 1) r.repeat_ticks = 16'd0;
      else r.repeat_ticks = 16'(i);
      send_request(r);
    end
    r = arm_request(4'd14, 32'hffff_ffff, 8'hff);
    r.repeat_ticks = 16'hffff;
    send_request(r);
    r = arm_request(4'd13, 32'd0, 8'd0);
    send_request(r);
    r = random_fill();
    r.req_type = REQ_TICK;
    r.task_present = 1'b0;
    send_request(r);
  endtask

  initial begin
    logic [7:0]  phase_rates [6];
    int          idle_plan [4];
    int          stall_plan [4];
    int          n;
    int          burst;
    bit          paused;
    logic [3:0]  slot;
    logic [31:0] sec;
    logic [7:0]  tick;

    phase_rates = '{8'd1, 8'd0, 8'd255, 8'd7, 8'd250, 8'd0};
    idle_plan = '{0, 45, 0, 18};
    stall_plan = '{0, 0, 45, 18};
    last_random_rate = 8'($urandom_range(2, 30));
    phase_rates[5] = last_random_rate;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_rate(phase_rates[p]);
      send_idle_pct = idle_plan[p % 4];
      recv_stall_pct <= stall_plan[p % 4];
      if (p == 4) hold_req <= hold_req + 1;
      n = 0;
      paused = 1'b0;
      while (n < ITEMS_PER_PHASE) begin
        if (p == 1 && !paused && n >= ITEMS_PER_PHASE / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 6) begin
          // several slots aimed at one moment
          burst = $urandom_range(2, TCTA_TASK_SLOTS);
          slot = 4'($urandom_range(0, 15));
          pick_alarm_time(sec, tick);
          if (sec == 32'd0) sec = sb.wall_sec;
          for (int j = 0; j < burst; j++) begin
            send_request(arm_request(slot, sec, tick));
            slot = slot + 4'd1;
          end
          n += burst;
        end else begin
          send_request(random_request());
          n++;
        end
      end
    end

    wait_idle();
    repeat (400) @(posedge clk);

    $display("%0d requests over tick rates 250, 1, 0, 255, 7, 250 and %0d with idle and stall mixes",
             requests_sent, last_random_rate);
    $display("%0d results checked, %0d alarm signals, up to %0d results from one request",
             sb.checked, sb.fired_count, sb.most_per_request);
    if (sb.errors == 0 && sb.expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
